[design/assert_macros.svh]
// Assertion macros shared by the poller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BPQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bus poller assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bus poller assertion failed");

`endif

[design/bpq_pkg.sv]
// Shared types, constants and helpers of the bus poller.
package bpq_pkg;

	localparam int SLOT_COUNT_DEF    = 8;
	localparam int QUEUE_DEPTH_DEF   = 8;
	localparam int HEADER_BYTES_DEF  = 2;
	localparam int PACKET_BYTES_DEF  = 8;
	localparam int INQUIRY_BYTES_DEF = 2;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STATUS_TIMEOUT = 8'd1;

	localparam logic [CFG_DATA_W-1:0] POLL_INTERVAL_RESET  = 16'd25;
	localparam logic [CFG_DATA_W-1:0] STATUS_TIMEOUT_RESET = 16'd1500;

	localparam logic [1:0] CMD_STATUS  = 2'd0;
	localparam logic [1:0] CMD_QUEUE   = 2'd1;
	localparam logic [1:0] CMD_SERVICE = 2'd2;

	typedef struct packed {
		logic status_wr;
		logic service;
	} slot_ctrl_t;

	typedef struct packed {
		logic [7:0] active_mask;
		logic [7:0] identify_mask;
		logic [7:0] sel_mode;
		logic [7:0] sel_phase;
	} slot_view_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic nonempty;
		logic push_ok;
	} queue_stat_t;

	// Keep bytes below the given count, clear the rest.
	function automatic logic [63:0] byte_mask(input logic [3:0] bytes);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[b*8 +: 8] = {8{4'(b) < bytes}};
		end
		return m;
	endfunction

endpackage

[design/bpq_if.sv]
// Valid/ready channels for input items and result items.
interface bpq_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] now_ms;
	logic [7:0]  address;
	logic [7:0]  status_mode;
	logic [7:0]  status_phase;
	logic        identify;
	logic [63:0] payload;
	logic [3:0]  length;
	logic        bus_ready;

	modport source (
		output valid, command, now_ms, address, status_mode, status_phase,
		       identify, payload, length, bus_ready,
		input  ready
	);
	modport sink (
		input  valid, command, now_ms, address, status_mode, status_phase,
		       identify, payload, length, bus_ready,
		output ready
	);
endinterface

interface bpq_result_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        send_valid;
	logic        send_is_inquiry;
	logic [2:0]  send_address;
	logic [63:0] send_payload;
	logic [3:0]  send_length;
	logic [7:0]  active_mask;
	logic [7:0]  identify_mask;
	logic [7:0]  sel_mode;
	logic [7:0]  sel_phase;

	modport source (
		output valid, accepted, send_valid, send_is_inquiry, send_address,
		       send_payload, send_length, active_mask, identify_mask,
		       sel_mode, sel_phase,
		input  ready
	);
	modport sink (
		input  valid, accepted, send_valid, send_is_inquiry, send_address,
		       send_payload, send_length, active_mask, identify_mask,
		       sel_mode, sel_phase,
		output ready
	);
endinterface

[design/bpq_queue.sv]
// Ring queue of outgoing command packets.
`include "assert_macros.svh"

module bpq_queue #(
	parameter int QUEUE_DEPTH  = bpq_pkg::QUEUE_DEPTH_DEF,
	parameter int HEADER_BYTES = bpq_pkg::HEADER_BYTES_DEF,
	parameter int PACKET_BYTES = bpq_pkg::PACKET_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpq_pkg::queue_ctrl_t ctrl,
	input  logic [63:0]         payload,
	input  logic [3:0]          length,
	output bpq_pkg::queue_stat_t stat,
	output logic [63:0]         head_payload,
	output logic [3:0]          head_length
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [63:0]   pay_mem [QUEUE_DEPTH];
	logic [3:0]    len_mem [QUEUE_DEPTH];
	logic [QW-1:0] rptr_q;
	logic [QW-1:0] wptr_q;
	logic [CW-1:0] count_q;
	logic          len_ok;
	logic          full;
	logic          push_ok;

	function automatic logic [QW-1:0] step(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign len_ok  = (length >= 4'(HEADER_BYTES)) && (length <= 4'(PACKET_BYTES));
	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign push_ok = ctrl.push && len_ok && !full;

	assign stat = '{nonempty: (count_q != '0), push_ok: push_ok};

	assign head_payload = pay_mem[rptr_q];
	assign head_length  = len_mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q  <= '0;
			wptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wptr_q  <= step(wptr_q);
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop) begin
				rptr_q  <= step(rptr_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Clear bytes past the length on the way in.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			pay_mem[wptr_q] <= payload & bpq_pkg::byte_mask(length);
			len_mem[wptr_q] <= length;
		end
	end

	`BPQ_ASSERT_IMP(a_q_pop_nonempty, ctrl.pop, count_q != '0)
	`BPQ_ASSERT_NEXT(a_q_pop_count, ctrl.pop && !push_ok, count_q == $past(count_q) - 1'b1)
	`BPQ_ASSERT_IMP(a_q_ptr_match, (count_q == '0) || full, rptr_q == wptr_q)

endmodule

[design/bpq_slots.sv]
// Per-slot status table with timeout expiry and read-back.
`include "assert_macros.svh"

module bpq_slots #(
	parameter int SLOT_COUNT = bpq_pkg::SLOT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpq_pkg::slot_ctrl_t ctrl,
	input  logic [31:0]         now_ms,
	input  logic [15:0]         timeout_ms,
	input  logic [7:0]          address,
	input  logic [7:0]          status_mode,
	input  logic [7:0]          status_phase,
	input  logic                identify,
	output bpq_pkg::slot_view_t view
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [31:0]           heard_q [SLOT_COUNT];
	logic [31:0]           heard_d [SLOT_COUNT];
	logic [7:0]            mode_q  [SLOT_COUNT];
	logic [7:0]            mode_d  [SLOT_COUNT];
	logic [7:0]            phase_q [SLOT_COUNT];
	logic [7:0]            phase_d [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] active_q;
	logic [SLOT_COUNT-1:0] active_d;
	logic [SLOT_COUNT-1:0] ident_q;
	logic [SLOT_COUNT-1:0] ident_d;
	logic                  in_range;
	logic [SW-1:0]         sel;
	logic [7:0]            amask;
	logic [7:0]            imask;

	assign in_range = (address < 8'(SLOT_COUNT));
	assign sel      = address[SW-1:0];

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
		logic        hit;
		logic [31:0] limit;
		logic [31:0] age;
		logic        expired;

		assign hit     = ctrl.status_wr && in_range && (address == 8'(i));
		assign limit   = heard_q[i] + {16'b0, timeout_ms};
		// Wrap-safe: deadline reached when now minus limit is non-negative.
		assign age     = now_ms - limit;
		assign expired = ctrl.service && active_q[i] && !age[31];

		assign active_d[i] = hit | (active_q[i] & ~expired);
		assign ident_d[i]  = hit ? identify : ident_q[i];
		assign heard_d[i]  = hit ? now_ms : heard_q[i];
		assign mode_d[i]   = hit ? status_mode : mode_q[i];
		assign phase_d[i]  = hit ? status_phase : phase_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			ident_q  <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				heard_q[i] <= '0;
				mode_q[i]  <= '0;
				phase_q[i] <= '0;
			end
		end else begin
			active_q <= active_d;
			ident_q  <= ident_d;
			heard_q  <= heard_d;
			mode_q   <= mode_d;
			phase_q  <= phase_d;
		end
	end

	// Masks cover slots 0..7 only.
	for (genvar i = 0; i < 8; i++) begin : g_mask
		if (i < SLOT_COUNT) begin : g_on
			assign amask[i] = active_d[i];
			assign imask[i] = ident_d[i];
		end else begin : g_off
			assign amask[i] = 1'b0;
			assign imask[i] = 1'b0;
		end
	end

	assign view = '{
		active_mask:   amask,
		identify_mask: imask,
		sel_mode:      in_range ? mode_d[sel] : 8'd0,
		sel_phase:     in_range ? phase_d[sel] : 8'd0
	};

	`BPQ_ASSERT_NEXT(a_svc_never_sets, ctrl.service, (active_q & ~$past(active_q)) == '0)

endmodule

[design/bus_poller_with_command_queue.sv]
// Top level of the round-robin bus poller with command queue.
// Each item is taken and its result beat is registered on the next clock
// edge; a new item is taken every cycle as long as the result register is
// empty or its beat is taken in the same cycle, so the sustained rate is
// one item per clock. The slot timeout checks run side by side in the slot
// table, and the queue head is read straight from its register file. Writes
// on the configuration port (index 0 poll interval, index 1 status timeout,
// others ignored) take effect on the next item.
`include "assert_macros.svh"

module bus_poller_with_command_queue #(
	parameter int SLOT_COUNT    = bpq_pkg::SLOT_COUNT_DEF,
	parameter int QUEUE_DEPTH   = bpq_pkg::QUEUE_DEPTH_DEF,
	parameter int HEADER_BYTES  = bpq_pkg::HEADER_BYTES_DEF,
	parameter int PACKET_BYTES  = bpq_pkg::PACKET_BYTES_DEF,
	parameter int INQUIRY_BYTES = bpq_pkg::INQUIRY_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bpq_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [bpq_pkg::CFG_DATA_W-1:0]   wr_data,
	bpq_item_if.sink                         item,
	bpq_result_if.source                     result
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [15:0]          poll_q;
	logic [15:0]          timeout_q;
	logic [31:0]          next_send_q;
	logic [SW-1:0]        next_poll_q;
	logic                 res_valid_q;

	logic                 accepted_q;
	logic                 send_valid_q;
	logic                 send_is_inquiry_q;
	logic [2:0]           send_address_q;
	logic [63:0]          send_payload_q;
	logic [3:0]           send_length_q;
	bpq_pkg::slot_view_t  view_q;

	logic                 in_ready;
	logic                 item_acc;
	logic                 is_status;
	logic                 is_push;
	logic                 is_service;
	logic [31:0]          slack;
	logic                 go;
	logic                 pop;
	logic                 inquiry;
	logic [31:0]          deadline_d;
	logic [3:0]           send_length_d;

	bpq_pkg::slot_ctrl_t  slot_ctrl;
	bpq_pkg::slot_view_t  slot_view;
	bpq_pkg::queue_ctrl_t q_ctrl;
	bpq_pkg::queue_stat_t q_stat;
	logic [63:0]          head_payload;
	logic [3:0]           head_length;

	assign in_ready   = !res_valid_q || result.ready;
	assign item.ready = in_ready;
	assign item_acc   = item.valid && in_ready;

	assign is_status  = item_acc && (item.command == bpq_pkg::CMD_STATUS);
	assign is_push    = item_acc && (item.command == bpq_pkg::CMD_QUEUE);
	assign is_service = item_acc && (item.command == bpq_pkg::CMD_SERVICE);

	// Send deadline reached when now minus deadline is non-negative.
	assign slack   = item.now_ms - next_send_q;
	assign go      = is_service && !slack[31] && item.bus_ready;
	assign pop     = go && q_stat.nonempty;
	assign inquiry = go && !q_stat.nonempty;

	assign deadline_d = item.now_ms + {16'b0, poll_q};

	always_comb begin
		if (pop) begin
			send_length_d = head_length;
		end else if (inquiry) begin
			send_length_d = 4'(INQUIRY_BYTES);
		end else begin
			send_length_d = 4'd0;
		end
	end

	assign slot_ctrl = '{status_wr: is_status, service: is_service};
	assign q_ctrl    = '{push: is_push, pop: pop};

	bpq_slots #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_slots (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (slot_ctrl),
		.now_ms       (item.now_ms),
		.timeout_ms   (timeout_q),
		.address      (item.address),
		.status_mode  (item.status_mode),
		.status_phase (item.status_phase),
		.identify     (item.identify),
		.view         (slot_view)
	);

	bpq_queue #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HEADER_BYTES (HEADER_BYTES),
		.PACKET_BYTES (PACKET_BYTES)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (q_ctrl),
		.payload      (item.payload),
		.length       (item.length),
		.stat         (q_stat),
		.head_payload (head_payload),
		.head_length  (head_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q      <= bpq_pkg::POLL_INTERVAL_RESET;
			timeout_q   <= bpq_pkg::STATUS_TIMEOUT_RESET;
			next_send_q <= '0;
			next_poll_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					bpq_pkg::REG_POLL_INTERVAL: begin
						poll_q <= wr_data;
					end
					bpq_pkg::REG_STATUS_TIMEOUT: begin
						timeout_q <= wr_data;
					end
					default: begin
					end
				endcase
			end
			if (go) begin
				next_send_q <= deadline_d;
			end
			if (inquiry) begin
				next_poll_q <= (next_poll_q == SW'(SLOT_COUNT - 1)) ? '0 : next_poll_q + 1'b1;
			end
			// Hold the beat until taken; refill on every accepted item.
			if (item_acc) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			accepted_q        <= q_stat.push_ok;
			send_valid_q      <= go;
			send_is_inquiry_q <= inquiry;
			send_address_q    <= inquiry ? 3'(next_poll_q) : 3'd0;
			send_payload_q    <= pop ? head_payload : 64'd0;
			send_length_q     <= send_length_d;
			view_q            <= slot_view;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.accepted        = accepted_q;
	assign result.send_valid      = send_valid_q;
	assign result.send_is_inquiry = send_is_inquiry_q;
	assign result.send_address    = send_address_q;
	assign result.send_payload    = send_payload_q;
	assign result.send_length     = send_length_q;
	assign result.active_mask     = view_q.active_mask;
	assign result.identify_mask   = view_q.identify_mask;
	assign result.sel_mode        = view_q.sel_mode;
	assign result.sel_phase       = view_q.sel_phase;

	`BPQ_ASSERT_NEXT(a_deadline_set, go, next_send_q == $past(deadline_d))

endmodule
